>>> design/yuvag_pkg.sv
// ----------------------------------------------------------------------------
// yuvag_pkg
// shared codes, widths, stage types and the chroma column map of the
// yuv layout address generator
// ----------------------------------------------------------------------------
package yuvag_pkg;

   // field widths
   localparam int unsigned POS_W  = 12;
   localparam int unsigned DIM_W  = 13;
   localparam int unsigned IDX_W  = 26;
   localparam int unsigned COL_W  = 18;
   localparam int unsigned ROW_W  = 13;
   localparam int unsigned SH_W   = 4;
   localparam int unsigned FMT_W  = 4;
   localparam int unsigned CSR_AW = 2;

   // layout codes
   localparam logic [FMT_W-1:0] FMT_P420     = 4'd0;
   localparam logic [FMT_W-1:0] FMT_P422     = 4'd1;
   localparam logic [FMT_W-1:0] FMT_P444     = 4'd2;
   localparam logic [FMT_W-1:0] FMT_YUY2     = 4'd3;
   localparam logic [FMT_W-1:0] FMT_UYVY     = 4'd4;
   localparam logic [FMT_W-1:0] FMT_UYVY_FLD = 4'd5;
   localparam logic [FMT_W-1:0] FMT_MB420    = 4'd6;
   localparam logic [FMT_W-1:0] FMT_MB420F   = 4'd7;
   localparam logic [FMT_W-1:0] FMT_MB422    = 4'd8;
   localparam logic [FMT_W-1:0] FMT_MB422F   = 4'd9;
   localparam logic [FMT_W-1:0] FMT_T44_420  = 4'd10;
   localparam logic [FMT_W-1:0] FMT_T44_422  = 4'd11;
   localparam logic [FMT_W-1:0] FMT_T88      = 4'd12;
   localparam logic [FMT_W-1:0] FMT_T84      = 4'd13;

   // plane codes
   localparam logic [1:0] PLANE_Y   = 2'd0;
   localparam logic [1:0] PLANE_CB  = 2'd1;
   localparam logic [1:0] PLANE_CR  = 2'd2;
   localparam logic [1:0] PLANE_BAD = 2'd3;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_LAYOUT  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_WIDTH   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_HEIGHT  = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_SWIZZLE = 2'd3;

   // macroblock: 512 elements, Cb at +256, Cr at +264
   localparam logic [SH_W-1:0] MB_SIZE_LOG2 = 4'd9;
   localparam int unsigned     MB_CB_OFS    = 256;
   localparam int unsigned     MB_CR_OFS    = 264;
   // 4x4 tile: 32 elements, chroma at +16, Cr at +16 + 8
   localparam logic [SH_W-1:0] T44_SIZE_LOG2 = 4'd5;

   localparam logic [2:0] SWZ_MAP [8] = '{3'd4, 3'd5, 3'd0, 3'd1, 3'd6, 3'd7, 3'd2, 3'd3};

   // macroblock chroma column map
   function automatic logic [2:0] swz_col(input logic [2:0] c, input logic en);
      swz_col = en ? SWZ_MAP[c] : c;
   endfunction

   // decoded item: index = offset + (row * pitch << sh) + col
   typedef struct packed {
      logic             bad;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [DIM_W-1:0] pitch;
      logic [SH_W-1:0]  sh;
      logic             off_en;
      logic             csz_en;
      logic [1:0]       csz_sh;
   } dec_type;

   typedef struct packed {
      dec_type          dec;
      logic [IDX_W-1:0] size;
   } sized_type;

   typedef struct packed {
      logic             bad;
      logic [COL_W-1:0] col;
      logic [SH_W-1:0]  sh;
      logic [IDX_W-1:0] prod;
      logic [IDX_W-1:0] offset;
   } prod_type;

   typedef struct packed {
      logic             bad;
      logic [IDX_W-1:0] index;
   } res_type;

endpackage

>>> design/yuv_layout_address_generator_unit.sv
// ----------------------------------------------------------------------------
// yuv_layout_address_generator_unit
// frame buffer element index of a luma or chroma sample for a yuv layout
// ----------------------------------------------------------------------------
// Takes a plane (luma, Cb, Cr) and a luma-grid pixel position and returns the
// element offset of that sample in a frame buffer of the configured layout:
// planar 4:2:0 / 4:2:2 / 4:4:4, YUY2, UYVY and field-interleaved UYVY, 16x16
// macroblock 4:2:0 and 4:2:2 (frame and field, optional chroma column map),
// packed 4x4 tiles and planar 8x8 / 8x4 tiles. Plane 3, the packed 4x4 4:2:2
// layout and the unused layout codes return index 0 with the bad_request flag
// set. The block is a four-stage pipeline (decode, frame-size multiply,
// row-pitch multiply, final add into the output register) and takes one
// transfer per clock while the result side is not stalled. Each stage holds
// its item independently, so a stalled output still lets bubbles upstream
// fill. Width and height above MAX_WIDTH / MAX_HEIGHT are clamped to those
// values; indexes wrap modulo 2^26. Write the registers only while the
// pipeline is empty.
// ----------------------------------------------------------------------------
module yuv_layout_address_generator_unit
   import yuvag_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic              clock,
   input  logic              reset,
   // configuration write port
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [DIM_W-1:0]  csr_wdata,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // pos_x [11:0], pos_y [23:12]
   input  logic [1:0]        req_tuser,   // plane [1:0]
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // element_index [25:0], zero [31:26]
   output logic [0:0]        rsp_tuser    // bad_request [0]
);

   // configuration registers
   logic [FMT_W-1:0] layout_ff, layout_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             swizzle_ff, swizzle_in;

   // pipeline valid bits and payload
   logic      v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   dec_type   s1_ff, s1_in;
   sized_type s2_ff, s2_in;
   prod_type  s3_ff, s3_in;
   res_type   s4_ff, s4_in;
   logic      en1, en2, en3, en4;

   // decode helpers
   logic [1:0]       pl;
   logic [POS_W-1:0] pos_x, pos_y;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [DIM_W-1:0] y_fld;
   logic [8:0]       half_rows;
   logic [DIM_W-1:0] mb_yin;
   logic             mb_c420, mb_par;
   logic [ROW_W-1:0] mb_row;
   logic [COL_W-1:0] mb_col;
   logic [1:0]       t_tys;
   logic [POS_W-1:0] t_px, t_py;
   logic [COL_W-1:0] t_col;
   logic [ROW_W-1:0] t_row;
   logic             p_cxs, p_cys;
   logic [IDX_W-1:0] size_prod;
   logic [IDX_W-1:0] csz;

   // ---------------------------------------------------------------- config
   always_comb begin
      layout_in  = layout_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      swizzle_in = swizzle_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_LAYOUT:  layout_in  = csr_wdata[FMT_W-1:0];
            CSR_WIDTH:   width_in   = csr_wdata;
            CSR_HEIGHT:  height_in  = csr_wdata;
            CSR_SWIZZLE: swizzle_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff  <= FMT_P420;
         width_ff   <= 13'd16;
         height_ff  <= 13'd16;
         swizzle_ff <= 1'b0;
      end else begin
         layout_ff  <= layout_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         swizzle_ff <= swizzle_in;
      end
   end

   // oversized frames are clamped to the supported maximum
   assign w_eff = (32'(width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (32'(height_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_ff;

   // ------------------------------------------------------- stage handshake
   // each stage loads when empty or when the next stage takes its item
   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   assign v1_in = en1 ? req_tvalid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ------------------------------------------------------- stage 1: decode
   assign pl    = req_tuser;
   assign pos_x = req_tdata[11:0];
   assign pos_y = req_tdata[23:12];

   // field-interleaved row: even lines first, odd lines from h/2 on
   assign y_fld     = DIM_W'(pos_y[11:1]) + (pos_y[0] ? DIM_W'(h_eff[12:1]) : '0);
   assign half_rows = 9'((10'(h_eff[12:4]) + 10'd1) >> 1);

   // 16x16 macroblock layouts
   always_comb begin
      case (layout_ff)
         FMT_MB420F: mb_yin = DIM_W'(pos_y[11:1]);
         FMT_MB422F: mb_yin = y_fld;
         default:    mb_yin = DIM_W'(pos_y);
      endcase
   end

   assign mb_c420 = (layout_ff == FMT_MB420) || (layout_ff == FMT_MB420F);
   // second field starts after the macroblock rows of the first one
   assign mb_par  = (layout_ff == FMT_MB420F) &&
                    ((pl == PLANE_Y) ? pos_y[0] : pos_y[1]);
   assign mb_row  = ROW_W'(mb_yin[12:4]) + (mb_par ? ROW_W'(half_rows) : '0);

   always_comb begin
      if (pl == PLANE_Y) begin
         mb_col = COL_W'({pos_x[11:4], 1'b0, mb_yin[3:0], pos_x[3:0]});
      end else begin
         mb_col = COL_W'({pos_x[11:4], 9'd0})
                + COL_W'(swz_col(pos_x[3:1], swizzle_ff))
                + (mb_c420 ? COL_W'({mb_yin[3:1], 4'd0}) : COL_W'({mb_yin[3:0], 4'd0}))
                + ((pl == PLANE_CB) ? COL_W'(MB_CB_OFS) : COL_W'(MB_CR_OFS));
      end
   end

   // planar 8x8 / 8x4 tiles
   assign t_tys = (layout_ff == FMT_T88) ? 2'd3 : 2'd2;
   assign t_px  = (pl == PLANE_Y) ? pos_x : {1'b0, pos_x[11:1]};
   assign t_py  = (pl == PLANE_Y) ? pos_y : {1'b0, pos_y[11:1]};
   assign t_col = (COL_W'(t_px[11:3]) << (3'd3 + 3'(t_tys)))
                + COL_W'(t_px[2:0])
                + (COL_W'(t_py & ((12'd1 << t_tys) - 12'd1)) << 3);
   assign t_row = ROW_W'(t_py >> t_tys);

   // planar subsampling shifts
   assign p_cxs = (layout_ff != FMT_P444);
   assign p_cys = (layout_ff == FMT_P420);

   always_comb begin
      s1_in        = '0;
      s1_in.pitch  = w_eff;
      s1_in.row    = ROW_W'(pos_y);
      case (layout_ff)
         FMT_P420, FMT_P422, FMT_P444: begin
            if (pl == PLANE_Y) begin
               s1_in.col = COL_W'(pos_x);
            end else begin
               s1_in.col    = COL_W'(pos_x >> p_cxs);
               s1_in.row    = ROW_W'(pos_y >> p_cys);
               s1_in.pitch  = w_eff >> p_cxs;
               s1_in.off_en = 1'b1;
               s1_in.csz_en = (pl == PLANE_CR);
               s1_in.csz_sh = 2'(p_cxs) + 2'(p_cys);
            end
         end
         FMT_YUY2: begin
            s1_in.sh = 4'd1;
            if (pl == PLANE_Y) begin
               s1_in.col = COL_W'({pos_x, 1'b0});
            end else begin
               s1_in.col = COL_W'({pos_x[11:1], (pl == PLANE_CR), 1'b1});
            end
         end
         FMT_UYVY, FMT_UYVY_FLD: begin
            s1_in.sh = 4'd1;
            if (layout_ff == FMT_UYVY_FLD) begin
               s1_in.row = y_fld;
            end
            if (pl == PLANE_Y) begin
               s1_in.col = COL_W'({pos_x, 1'b1});
            end else begin
               s1_in.col = COL_W'({pos_x[11:1], (pl == PLANE_CR), 1'b0});
            end
         end
         FMT_MB420, FMT_MB420F, FMT_MB422, FMT_MB422F: begin
            s1_in.col   = mb_col;
            s1_in.row   = mb_row;
            s1_in.pitch = DIM_W'(w_eff[12:4]);
            s1_in.sh    = MB_SIZE_LOG2;
         end
         FMT_T44_420: begin
            s1_in.row   = ROW_W'(pos_y[11:2]);
            s1_in.pitch = DIM_W'(w_eff[12:2]);
            s1_in.sh    = T44_SIZE_LOG2;
            if (pl == PLANE_Y) begin
               s1_in.col = COL_W'({pos_x[11:2], 1'b0, pos_y[1:0], pos_x[1:0]});
            end else begin
               s1_in.col = COL_W'({pos_x[11:2], 1'b1, (pl == PLANE_CR), pos_y[1],
                                   1'b0, pos_x[1]});
            end
         end
         FMT_T88, FMT_T84: begin
            s1_in.col = t_col;
            s1_in.row = t_row;
            s1_in.sh  = SH_W'(t_tys);
            if (pl != PLANE_Y) begin
               s1_in.pitch  = w_eff >> 1;
               s1_in.off_en = 1'b1;
               s1_in.csz_en = (pl == PLANE_CR);
               s1_in.csz_sh = 2'd2;
            end
         end
         default: begin
            // packed 4x4 4:2:2 and the unused codes
            s1_in.bad = 1'b1;
         end
      endcase
      if (pl == PLANE_BAD) begin
         s1_in.bad = 1'b1;
      end
   end

   // ---------------------------------------------- stage 2: luma plane size
   assign size_prod = w_eff * h_eff;

   always_comb begin
      s2_in.dec  = s1_ff;
      s2_in.size = size_prod;
   end

   // ------------------------------------ stage 3: row product, plane offset
   assign csz = s2_ff.size >> s2_ff.dec.csz_sh;

   always_comb begin
      s3_in.bad    = s2_ff.dec.bad;
      s3_in.col    = s2_ff.dec.col;
      s3_in.sh     = s2_ff.dec.sh;
      s3_in.prod   = s2_ff.dec.row * s2_ff.dec.pitch;
      s3_in.offset = '0;
      if (s2_ff.dec.off_en) begin
         s3_in.offset = s2_ff.size + (s2_ff.dec.csz_en ? csz : '0);
      end
   end

   // ------------------------------------------------ stage 4: final sum
   always_comb begin
      s4_in.bad   = s3_ff.bad;
      s4_in.index = '0;
      if (!s3_ff.bad) begin
         s4_in.index = s3_ff.offset + (s3_ff.prod << s3_ff.sh) + IDX_W'(s3_ff.col);
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s2_in;
      end
      if (en3) begin
         s3_ff <= s3_in;
      end
      if (en4) begin
         s4_ff <= s4_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {6'd0, s4_ff.index};
   assign rsp_tuser  = s4_ff.bad;

   // ------------------------------------------------------------ assertions
   // a flagged result always carries index zero
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 32'd0))
      else $error("flagged result with nonzero index");

   // a full pipeline with a stalled output takes no new transfer
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline full and stalled");

   // with the result side open, an accepted item reaches the output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready)
      |=> rsp_tvalid)
      else $error("accepted item did not reach the output register");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!v1_ff && !v2_ff && !v3_ff && !rsp_tvalid))
      else $error("pipeline not empty after reset");

endmodule

>>> sim/tb_yuv_layout_address_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuv_layout_address_generator_unit
// self-checking bench for the yuv frame buffer address generator
// ----------------------------------------------------------------------------
// A directed table first walks the reset layout, the error cases (invalid
// plane, unimplemented and unused layout codes), oversized and zero frame
// sizes and a sample of every layout family. Random phases then go
// through all layout codes and many frame sizes, with random planes and
// positions. Request transfers are scored by an address predictor kept in
// the bench or by a result given in the table, and result transfers are
// compared in order against them. Both handshake sides idle at random,
// with one stretch of phases at full rate.
// ----------------------------------------------------------------------------
module tb_yuv_layout_address_generator_unit;
   import yuvag_pkg::*;

   localparam int unsigned MAX_W           = 4096;
   localparam int unsigned MAX_H           = 4096;
   localparam int unsigned NUM_DIR_ROWS    = 45;
   localparam int unsigned NUM_PHASES      = 32;
   localparam int unsigned ITEMS_PER_PHASE = 45;
   localparam int unsigned PIPE_CYCLES     = 8;       // settle time after the last result
   localparam int unsigned CYCLE_LIMIT     = 200000;  // run watchdog

   // layout codes with no layout behind them
   localparam logic [FMT_W-1:0] FMT_UNUSED_A = 4'd14;
   localparam logic [FMT_W-1:0] FMT_UNUSED_B = 4'd15;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             bad;
   } addr_result_type;

   typedef enum logic {ROW_CSR, ROW_XFER} row_kind_type;

   // one step of the directed table: a register write or a request transfer
   typedef struct packed {
      row_kind_type      kind;
      logic [CSR_AW-1:0] sel;
      logic [DIM_W-1:0]  value;
      logic [1:0]        plane;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic              typed;   // expected result given in the row
      addr_result_type   want;
   } dir_row_type;

   // dut ports; the inputs are known from time zero
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [DIM_W-1:0]  csr_wdata  = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata  = '0;   // pos_x [11:0], pos_y [23:12]
   logic [1:0]        req_tuser  = '0;   // plane [1:0]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;         // element_index [25:0], zero [31:26]
   logic [0:0]        rsp_tuser;         // bad_request [0]

   // shadow copy of the layout registers
   logic [FMT_W-1:0] cfg_layout  = FMT_P420;
   logic [DIM_W-1:0] cfg_width   = 13'd16;
   logic [DIM_W-1:0] cfg_height  = 13'd16;
   logic             cfg_swizzle = 1'b0;

   // macroblock chroma column order when the swizzle is on
   int unsigned chroma_order [8] = '{4, 5, 0, 1, 6, 7, 2, 3};

   addr_result_type pending_addresses [$];
   addr_result_type scored;
   dir_row_type     directed_table [NUM_DIR_ROWS];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count    = 0;
   bit              calm           = 1'b0;   // no idling on either side

   yuv_layout_address_generator_unit #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // address predictor
   // ------------------------------------------------------------------------

   // uyvy: U0 Y0 V0 Y1, two bytes per pixel
   function automatic longint unsigned uyvy_index(input logic [1:0] pl,
                                                  input longint unsigned x, y, w);
      longint unsigned row;
      row = y * 2 * w;
      if (pl == PLANE_Y) return x * 2 + 1 + row;
      return (x / 2) * 4 + ((pl == PLANE_CB) ? 0 : 2) + row;
   endfunction

   // 16x16 macroblock of 512 elements: luma, Cb at +256, Cr at +264, rows of 16
   function automatic longint unsigned mb_index(input logic [1:0] pl,
                                                input longint unsigned x, y,
                                                input bit c420,
                                                input longint unsigned w);
      longint unsigned mbw, cx, cy, rows, col;
      mbw = w / 16;
      if (pl == PLANE_Y) return ((x / 16) + (y / 16) * mbw) * 512 + x % 16 + (y % 16) * 16;
      cx   = x / 2;
      cy   = c420 ? y / 2 : y;
      rows = c420 ? 8 : 16;
      col  = cfg_swizzle ? chroma_order[cx % 8] : cx % 8;
      return ((cx / 8) + (cy / rows) * mbw) * 512 + col + (cy % rows) * 16
             + ((pl == PLANE_CB) ? MB_CB_OFS : MB_CR_OFS);
   endfunction

   function automatic addr_result_type predict_element_index(input logic [1:0] pl,
                                                             input logic [POS_W-1:0] pos_x,
                                                             input logic [POS_W-1:0] pos_y);
      longint unsigned x, y, w, h, sz, r, cxd, cyd, cx, cy, fld, par;
      longint unsigned tx, ty, px, py, pw, off;
      addr_result_type res;
      x   = pos_x;
      y   = pos_y;
      // oversized frames clamp to the maximum
      w   = (cfg_width > MAX_W) ? MAX_W : cfg_width;
      h   = (cfg_height > MAX_H) ? MAX_H : cfg_height;
      sz  = w * h;
      r   = 0;
      res.bad = 1'b0;
      if (pl == PLANE_BAD) begin
         res.bad = 1'b1;
      end else begin
         case (cfg_layout)
            FMT_P420, FMT_P422, FMT_P444: begin
               cxd = (cfg_layout == FMT_P444) ? 1 : 2;
               cyd = (cfg_layout == FMT_P420) ? 2 : 1;
               if (pl == PLANE_Y) r = x + y * w;
               else r = sz + ((pl == PLANE_CR) ? sz / (cxd * cyd) : 0)
                        + x / cxd + (y / cyd) * (w / cxd);
            end
            FMT_YUY2: begin
               // Y0 U0 Y1 V0
               if (pl == PLANE_Y) r = x * 2 + y * 2 * w;
               else r = (x / 2) * 4 + ((pl == PLANE_CB) ? 1 : 3) + y * 2 * w;
            end
            FMT_UYVY:     r = uyvy_index(pl, x, y, w);
            FMT_UYVY_FLD: r = uyvy_index(pl, x, y / 2 + (y % 2) * (h / 2), w);
            FMT_MB420:    r = mb_index(pl, x, y, 1'b1, w);
            FMT_MB420F: begin
               // second field starts after half the macroblock rows, rounded up
               fld = ((h / 16 + 1) / 2) * (w / 16) * 512;
               par = (pl == PLANE_Y) ? y % 2 : (y / 2) % 2;
               r   = par * fld + mb_index(pl, x, y / 2, 1'b1, w);
            end
            FMT_MB422:  r = mb_index(pl, x, y, 1'b0, w);
            FMT_MB422F: r = mb_index(pl, x, y / 2 + (y % 2) * (h / 2), 1'b0, w);
            FMT_T44_420: begin
               // 32 element tile: 16 luma, 4 Cb, 4 spare, 4 Cr, 4 spare
               if (pl == PLANE_Y) begin
                  r = ((x / 4) + (y / 4) * (w / 4)) * 32 + x % 4 + (y % 4) * 4;
               end else begin
                  cx = x / 2;
                  cy = y / 2;
                  r  = ((cx / 2) + (cy / 2) * (w / 4)) * 32 + cx % 2 + (cy % 2) * 4
                       + 16 + ((pl == PLANE_CR) ? 8 : 0);
               end
            end
            FMT_T88, FMT_T84: begin
               tx  = 8;
               ty  = (cfg_layout == FMT_T88) ? 8 : 4;
               px  = x;
               py  = y;
               pw  = w;
               off = 0;
               if (pl != PLANE_Y) begin
                  pw  = w / 2;
                  px  = x / 2;
                  py  = y / 2;
                  off = sz + ((pl == PLANE_CR) ? sz / 4 : 0);
               end
               r = off + (px / tx) * tx * ty + (py / ty) * pw * ty + px % tx + (py % ty) * tx;
            end
            // packed 4x4 4:2:2 and unused codes
            default: res.bad = 1'b1;
         endcase
      end
      res.index = res.bad ? '0 : r[IDX_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_addresses.size() == 0) begin
            $display("%0t: unexpected result transfer, index %0d bad %0b",
                     $time, rsp_tdata[IDX_W-1:0], rsp_tuser[0]);
            mismatch_count = mismatch_count + 1;
         end else begin
            scored = pending_addresses.pop_front();
            if (rsp_tdata !== {{(32 - IDX_W){1'b0}}, scored.index}) begin
               $display("%0t: element_index expected %0d got %0d (tdata %h)",
                        $time, scored.index, rsp_tdata[IDX_W-1:0], rsp_tdata);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tuser[0] !== scored.bad) begin
               $display("%0t: bad_request expected %0b got %0b",
                        $time, scored.bad, rsp_tuser[0]);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // result side back-pressure, about one cycle in ten
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 10);
   end

   // ------------------------------------------------------------------------
   // stimulus helpers, all entered and left at a falling edge
   // ------------------------------------------------------------------------

   // one request transfer; the expectation is queued when it is accepted
   task automatic send_request(input logic [1:0] pl, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic typed,
                               input addr_result_type want);
      while (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tuser  <= pl;
      do @(posedge clock); while (!req_tready);
      pending_addresses.push_back(typed ? want : predict_element_index(pl, x, y));
      @(negedge clock);
   endtask

   // register write once the pipeline has drained
   task automatic write_csr(input logic [CSR_AW-1:0] sel, input logic [DIM_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_addresses.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= sel;
      csr_wdata <= value;
      case (sel)
         CSR_LAYOUT:  cfg_layout  = value[FMT_W-1:0];
         CSR_WIDTH:   cfg_width   = value;
         CSR_HEIGHT:  cfg_height  = value;
         CSR_SWIZZLE: cfg_swizzle = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic dir_row_type csr_row(input logic [CSR_AW-1:0] sel,
                                           input logic [DIM_W-1:0] value);
      dir_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.sel   = sel;
      row.value = value;
      return row;
   endfunction

   function automatic dir_row_type xfer_row(input logic [1:0] pl, input int unsigned x,
                                            input int unsigned y);
      dir_row_type row;
      row       = '0;
      row.kind  = ROW_XFER;
      row.plane = pl;
      row.x     = POS_W'(x);
      row.y     = POS_W'(y);
      return row;
   endfunction

   function automatic dir_row_type known_row(input logic [1:0] pl, input int unsigned x,
                                             input int unsigned y, input int unsigned idx,
                                             input logic bad);
      dir_row_type row;
      row            = xfer_row(pl, x, y);
      row.typed      = 1'b1;
      row.want.index = IDX_W'(idx);
      row.want.bad   = bad;
      return row;
   endfunction

   // frame size for a random phase, extremes included
   function automatic logic [DIM_W-1:0] pick_dim(input int unsigned sel);
      case (sel % 7)
         0:       return 13'd4096;
         1:       return 13'd16;
         2:       return 13'($urandom_range(8191, 4097));   // clamped by the block
         3:       return 13'($urandom_range(15));           // zero or tiny
         4:       return 13'($urandom_range(4096, 16));     // any size, odd too
         default: return 13'($urandom_range(256, 1) * 16);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [1:0]       pl;
      logic [POS_W-1:0] x, y;
      int unsigned      lim_x, lim_y;

      directed_table = '{
         // reset layout: planar 4:2:0, 16x16
         known_row(PLANE_Y,    0,    0,     0, 1'b0),
         known_row(PLANE_Y, 4095, 4095, 69615, 1'b0),   // far outside the frame
         known_row(PLANE_CB,   0,    0,   256, 1'b0),
         known_row(PLANE_CR,   0,    0,   320, 1'b0),
         known_row(PLANE_BAD, 4095, 4095,  0, 1'b1),    // invalid plane
         xfer_row(PLANE_CR, 4095, 4095),
         // packed 4x4 4:2:2 is not implemented
         csr_row(CSR_LAYOUT, DIM_W'(FMT_T44_422)),
         known_row(PLANE_Y,    5,    5,     0, 1'b1),
         known_row(PLANE_CB,   7,    3,     0, 1'b1),
         // unused layout codes
         csr_row(CSR_LAYOUT, DIM_W'(FMT_UNUSED_A)),
         known_row(PLANE_CR, 100,  200,     0, 1'b1),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_UNUSED_B)),
         known_row(PLANE_Y,    0,    0,     0, 1'b1),
         // oversized frame clamps to 4096x4096
         csr_row(CSR_LAYOUT, DIM_W'(FMT_P444)),
         csr_row(CSR_WIDTH, 13'd8191),
         csr_row(CSR_HEIGHT, 13'd8191),
         known_row(PLANE_Y, 4095, 4095, 16777215, 1'b0),
         xfer_row(PLANE_CR, 4095, 4095),
         // zero width
         csr_row(CSR_WIDTH, 13'd0),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_P420)),
         known_row(PLANE_Y,  4095, 4095,  4095, 1'b0),
         known_row(PLANE_CB, 4095, 4095,  2047, 1'b0),
         // packed layouts at 16x16
         csr_row(CSR_WIDTH, 13'd16),
         csr_row(CSR_HEIGHT, 13'd16),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_UYVY)),
         known_row(PLANE_Y,    1,    0,     3, 1'b0),
         known_row(PLANE_CR,   1,    0,     2, 1'b0),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_YUY2)),
         known_row(PLANE_CB,   2,    0,     5, 1'b0),
         xfer_row(PLANE_Y, 15, 15),
         // macroblock layouts with the chroma column map on
         csr_row(CSR_LAYOUT, DIM_W'(FMT_MB420)),
         csr_row(CSR_SWIZZLE, 13'd1),
         xfer_row(PLANE_CB, 2, 0),
         xfer_row(PLANE_CR, 15, 15),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_MB420F)),
         xfer_row(PLANE_Y, 3, 1),
         xfer_row(PLANE_CB, 3, 2),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_MB422F)),
         xfer_row(PLANE_CR, 9, 7),
         // tiled layouts
         csr_row(CSR_LAYOUT, DIM_W'(FMT_T44_420)),
         xfer_row(PLANE_CR, 13, 11),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_T84)),
         xfer_row(PLANE_CB, 4095, 0),
         csr_row(CSR_LAYOUT, DIM_W'(FMT_T88)),
         xfer_row(PLANE_Y, 0, 4095)
      };

      // synchronous reset
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_table[i]) begin
         if (directed_table[i].kind == ROW_CSR) begin
            write_csr(directed_table[i].sel, directed_table[i].value);
         end else begin
            send_request(directed_table[i].plane, directed_table[i].x, directed_table[i].y,
                         directed_table[i].typed, directed_table[i].want);
         end
      end

      // random phases, each with a fresh layout setting
      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         write_csr(CSR_LAYOUT, (phase < 16) ? DIM_W'(phase) : DIM_W'($urandom_range(13)));
         write_csr(CSR_WIDTH, pick_dim(phase));
         write_csr(CSR_HEIGHT, pick_dim(phase + 3));
         write_csr(CSR_SWIZZLE, DIM_W'($urandom_range(1)));
         // a stretch of phases at full rate on both sides
         calm = (phase >= 20 && phase < 24);
         lim_x = (cfg_width == 0) ? 0 : ((cfg_width > MAX_W) ? MAX_W : cfg_width) - 1;
         lim_y = (cfg_height == 0) ? 0 : ((cfg_height > MAX_H) ? MAX_H : cfg_height) - 1;
         for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
            pl = ($urandom_range(99) < 8) ? PLANE_BAD : 2'($urandom_range(2));
            if ($urandom_range(9) < 7) begin
               // inside the frame
               x = POS_W'($urandom_range(lim_x));
               y = POS_W'($urandom_range(lim_y));
            end else begin
               x = POS_W'($urandom_range(4095));
               y = POS_W'($urandom_range(4095));
            end
            // hold off the sender once until the pipeline is empty
            if (phase == 5 && k == ITEMS_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               while (pending_addresses.size() != 0) @(posedge clock);
               @(negedge clock);
            end
            send_request(pl, x, y, 1'b0, '0);
         end
      end
      calm = 1'b0;

      // drain and finish
      req_tvalid <= 1'b0;
      while (pending_addresses.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
